/* rtl/core/imu_bm_pkg.sv */
// types, constants and control signal bundles of the imu bias running mean block
`default_nettype none
package imu_bm_pkg;

    localparam int SAMPLE_WIDTH = 24;
    localparam int FRAC_BITS    = 16;
    localparam int AXES         = 6;
    localparam int AXIS_W       = $clog2(AXES);
    localparam int AXIS_ACC_Z   = 2;
    localparam int COUNT_W      = 17;
    localparam int LIMIT_W      = 16;
    // dividend magnitude of x - mean needs one bit more than a sample
    localparam int QUOT_W       = SAMPLE_WIDTH + 1;
    localparam int STEP_W       = $clog2(QUOT_W);
    localparam int REM_W        = COUNT_W + 1;

    localparam logic [COUNT_W-1:0] COUNT_ONE   = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] COUNT_MAX   = COUNT_W'(65536);
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(100);

    // -1.0 in the sample format, clamped to the most negative code when it does not fit
    localparam logic signed [SAMPLE_WIDTH-1:0] ACC_Z_RESET =
        (FRAC_BITS >= SAMPLE_WIDTH - 1) ? {1'b1, {(SAMPLE_WIDTH-1){1'b0}}}
                                        : SAMPLE_WIDTH'(-(longint'(1) <<< FRAC_BITS));

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] acc_x;
        logic signed [SAMPLE_WIDTH-1:0] acc_y;
        logic signed [SAMPLE_WIDTH-1:0] acc_z;
        logic signed [SAMPLE_WIDTH-1:0] gyr_x;
        logic signed [SAMPLE_WIDTH-1:0] gyr_y;
        logic signed [SAMPLE_WIDTH-1:0] gyr_z;
        logic                           group_end;
    } t_imu_in;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] avg_acc_x;
        logic signed [SAMPLE_WIDTH-1:0] avg_acc_y;
        logic signed [SAMPLE_WIDTH-1:0] avg_acc_z;
        logic signed [SAMPLE_WIDTH-1:0] avg_gyr_x;
        logic signed [SAMPLE_WIDTH-1:0] avg_gyr_y;
        logic signed [SAMPLE_WIDTH-1:0] avg_gyr_z;
        logic [COUNT_W-1:0]             samples_seen;
        logic                           init_done;
    } t_imu_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECIDE,
        S_DIV_LOAD,
        S_DIV_STEP,
        S_MEAN_UPD,
        S_COUNT_UPD,
        S_OUTPUT
    } t_ctrl_state;

    typedef struct packed {
        logic capture;
        logic seed;
        logic div_load;
        logic div_step;
        logic mean_upd;
        logic count_upd;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic first;
        logic div_last;
        logic axis_last;
        logic out_free;
    } t_dp_stat;

endpackage
`default_nettype wire

/* rtl/core/imu_bm_dp.sv */
// datapath: sample and mean registers, shared serial divider, count and output register
`default_nettype none
module imu_bm_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire imu_bm_pkg::t_dp_cmd           i_cmd,
    output imu_bm_pkg::t_dp_stat               o_stat,
    input  wire imu_bm_pkg::t_imu_in           i_in_data,
    input  wire logic                          i_cfg_we,
    input  wire logic [imu_bm_pkg::LIMIT_W-1:0] i_cfg_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output imu_bm_pkg::t_imu_out               o_out_data
);
    import imu_bm_pkg::*;

    logic signed [SAMPLE_WIDTH-1:0] r_x [AXES];
    logic signed [SAMPLE_WIDTH-1:0] r_mean [AXES];
    logic signed [SAMPLE_WIDTH-1:0] in_axes [AXES];
    logic                           r_group_end;
    logic [COUNT_W-1:0]             r_count;
    logic [COUNT_W-1:0]             n_count;
    logic                           r_first;
    logic                           r_done;
    logic [LIMIT_W-1:0]             r_limit;
    logic [AXIS_W-1:0]              r_axis;
    logic [STEP_W-1:0]              r_step;
    logic [QUOT_W-1:0]              r_quot;
    logic [REM_W-1:0]               r_rem;
    logic                           r_neg;
    logic                           r_out_valid;
    t_imu_out                       r_out;

    logic signed [QUOT_W-1:0]       diff;
    logic [QUOT_W-1:0]              diff_mag;
    logic [REM_W-1:0]               rem_sh;
    logic                           rem_ge;
    logic signed [QUOT_W:0]         quot_s;
    logic signed [QUOT_W:0]         mean_sum;

    assign in_axes[0] = i_in_data.acc_x;
    assign in_axes[1] = i_in_data.acc_y;
    assign in_axes[2] = i_in_data.acc_z;
    assign in_axes[3] = i_in_data.gyr_x;
    assign in_axes[4] = i_in_data.gyr_y;
    assign in_axes[5] = i_in_data.gyr_z;

    always_comb begin
        diff     = QUOT_W'(r_x[r_axis]) - QUOT_W'(r_mean[r_axis]);
        diff_mag = diff[QUOT_W-1] ? QUOT_W'(-diff) : QUOT_W'(diff);
        rem_sh   = {r_rem[REM_W-2:0], r_quot[QUOT_W-1]};
        rem_ge   = (rem_sh >= REM_W'(r_count));
        quot_s   = r_neg ? -$signed({1'b0, r_quot}) : $signed({1'b0, r_quot});
        mean_sum = (QUOT_W+1)'(r_mean[r_axis]) + quot_s;
        n_count  = (r_count < COUNT_MAX) ? r_count + COUNT_ONE : r_count;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= COUNT_ONE;
            r_first     <= 1'b1;
            r_done      <= 1'b0;
            r_limit     <= LIMIT_RESET;
            r_axis      <= '0;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
            if (i_cmd.capture) begin
                r_axis <= '0;
            end else if (i_cmd.mean_upd && r_axis != AXIS_W'(AXES - 1)) begin
                r_axis <= r_axis + AXIS_W'(1);
            end
            if (i_cmd.div_load) begin
                r_step <= '0;
            end else if (i_cmd.div_step) begin
                r_step <= r_step + STEP_W'(1);
            end
            if (i_cmd.seed) begin
                r_first <= 1'b0;
            end
            if (i_cmd.count_upd) begin
                r_count <= n_count;
                if (r_group_end && n_count > COUNT_W'(r_limit)) begin
                    r_done <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // means, with their reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_mean[i] <= (i == AXIS_ACC_Z) ? ACC_Z_RESET : '0;
            end
        end else if (i_cmd.seed) begin
            for (int i = 0; i < AXES; i++) begin
                r_mean[i] <= r_x[i];
            end
        end else if (i_cmd.mean_upd) begin
            r_mean[r_axis] <= mean_sum[SAMPLE_WIDTH-1:0];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int i = 0; i < AXES; i++) begin
                r_x[i] <= in_axes[i];
            end
            r_group_end <= i_in_data.group_end;
        end
        // restoring division of |x - mean| by the count, one quotient bit per cycle
        if (i_cmd.div_load) begin
            r_quot <= diff_mag;
            r_rem  <= '0;
            r_neg  <= diff[QUOT_W-1];
        end else if (i_cmd.div_step) begin
            r_quot <= {r_quot[QUOT_W-2:0], rem_ge};
            r_rem  <= rem_ge ? rem_sh - REM_W'(r_count) : rem_sh;
        end
        if (i_cmd.out_load) begin
            r_out.avg_acc_x    <= r_mean[0];
            r_out.avg_acc_y    <= r_mean[1];
            r_out.avg_acc_z    <= r_mean[2];
            r_out.avg_gyr_x    <= r_mean[3];
            r_out.avg_gyr_y    <= r_mean[4];
            r_out.avg_gyr_z    <= r_mean[5];
            r_out.samples_seen <= r_count;
            r_out.init_done    <= r_done;
        end
    end

    assign o_stat.done      = r_done;
    assign o_stat.first     = r_first;
    assign o_stat.div_last  = (r_step == STEP_W'(QUOT_W - 1));
    assign o_stat.axis_last = (r_axis == AXIS_W'(AXES - 1));
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
`default_nettype wire

/* rtl/core/imu_bm_ctrl.sv */
// controller: sequences capture, seeding, six serial divisions, count update and output
`default_nettype none
module imu_bm_ctrl (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    output imu_bm_pkg::t_dp_cmd      o_cmd,
    input  wire imu_bm_pkg::t_dp_stat i_stat
);
    import imu_bm_pkg::*;

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (i_stat.done) begin
                    n_state = S_OUTPUT;
                end else if (i_stat.first) begin
                    n_state = S_COUNT_UPD;
                end else begin
                    n_state = S_DIV_LOAD;
                end
            end
            S_DIV_LOAD: n_state = S_DIV_STEP;
            S_DIV_STEP: begin
                if (i_stat.div_last) begin
                    n_state = S_MEAN_UPD;
                end
            end
            S_MEAN_UPD: begin
                n_state = i_stat.axis_last ? S_COUNT_UPD : S_DIV_LOAD;
            end
            S_COUNT_UPD: n_state = S_OUTPUT;
            S_OUTPUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_DECIDE: begin
                // first request after reset seeds the means directly
                o_cmd.seed = !i_stat.done && i_stat.first;
            end
            S_DIV_LOAD:  o_cmd.div_load  = 1'b1;
            S_DIV_STEP:  o_cmd.div_step  = 1'b1;
            S_MEAN_UPD:  o_cmd.mean_upd  = 1'b1;
            S_COUNT_UPD: o_cmd.count_upd = 1'b1;
            S_OUTPUT:    o_cmd.out_load  = i_stat.out_free;
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/imu_bias_running_mean.sv */
// top level of the imu bias running mean block
//
// channel  | valid       | ready       | payload
// ---------+-------------+-------------+--------------------------
// input    | i_in_valid  | o_in_ready  | i_in_data  (t_imu_in)
// output   | o_out_valid | i_out_ready | o_out_data (t_imu_out)
// config   | i_cfg_we    | (none)      | i_cfg_data (sample limit)
//
// a request that updates the means runs a serial division per axis on the shared
// restoring divider, which gives one quotient bit a cycle; the seed request and
// requests after init completes skip the divisions, the latter the count update too
// synchronous active-low reset; the result sits in an output register, so the next
// request is accepted while it waits; a stalled output holds the next result back
`default_nettype none
module imu_bias_running_mean (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_ready,
    input  wire imu_bm_pkg::t_imu_in            i_in_data,
    output logic                                o_out_valid,
    input  wire logic                           i_out_ready,
    output imu_bm_pkg::t_imu_out                o_out_data,
    input  wire logic                           i_cfg_we,
    input  wire logic [imu_bm_pkg::LIMIT_W-1:0] i_cfg_data
);
    import imu_bm_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    imu_bm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    imu_bm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
`default_nettype wire

/* dv/tb.sv */
// testbench for imu_bias_running_mean: running-mean scoreboard and random valid/ready traffic
`timescale 1ns / 1ps
module tb;
    import imu_bm_pkg::*;

    // expected result queue plus a copy of the block's mean, count and limit state
    class mean_scoreboard;
        longint      means [AXES];
        int unsigned divisor;
        bit          seed_pending;
        bit          frozen;
        int unsigned sample_limit;
        t_imu_out    expected_means [$];
        int          errors;

        function new();
            foreach (means[a]) means[a] = 0;
            means[AXIS_ACC_Z] = longint'(ACC_Z_RESET);
            divisor      = 1;
            seed_pending = 1'b1;
            frozen       = 1'b0;
            sample_limit = int'(LIMIT_RESET);
            errors       = 0;
        endfunction

        function void set_limit(int unsigned value);
            sample_limit = value;
        endfunction

        function void note_request(t_imu_in req);
            longint   x [AXES];
            t_imu_out res;
            x = '{longint'(req.acc_x), longint'(req.acc_y), longint'(req.acc_z),
                  longint'(req.gyr_x), longint'(req.gyr_y), longint'(req.gyr_z)};
            if (!frozen) begin
                if (seed_pending) begin
                    foreach (means[a]) means[a] = x[a];
                    divisor      = 1;
                    seed_pending = 1'b0;
                end
                // quotient truncates toward zero, same as signed division here
                foreach (means[a]) means[a] += (x[a] - means[a]) / longint'(divisor);
                if (divisor < COUNT_MAX) divisor++;
                if (req.group_end && divisor > sample_limit) frozen = 1'b1;
            end
            res.avg_acc_x    = SAMPLE_WIDTH'(means[0]);
            res.avg_acc_y    = SAMPLE_WIDTH'(means[1]);
            res.avg_acc_z    = SAMPLE_WIDTH'(means[2]);
            res.avg_gyr_x    = SAMPLE_WIDTH'(means[3]);
            res.avg_gyr_y    = SAMPLE_WIDTH'(means[4]);
            res.avg_gyr_z    = SAMPLE_WIDTH'(means[5]);
            res.samples_seen = COUNT_W'(divisor);
            res.init_done    = frozen;
            expected_means.push_back(res);
        endfunction

        task report(string msg);
            $display("%0t tb mismatch: %s", $time, msg);
            errors++;
        endtask

        task compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
                report($sformatf("%s expected %0d got %0d", name, $signed(want), $signed(got)));
        endtask

        task check_result(t_imu_out got);
            t_imu_out want;
            if (expected_means.size() == 0) begin
                report("result with no request outstanding");
                return;
            end
            want = expected_means.pop_front();
            compare_field("avg_acc_x", 32'(want.avg_acc_x), 32'(got.avg_acc_x));
            compare_field("avg_acc_y", 32'(want.avg_acc_y), 32'(got.avg_acc_y));
            compare_field("avg_acc_z", 32'(want.avg_acc_z), 32'(got.avg_acc_z));
            compare_field("avg_gyr_x", 32'(want.avg_gyr_x), 32'(got.avg_gyr_x));
            compare_field("avg_gyr_y", 32'(want.avg_gyr_y), 32'(got.avg_gyr_y));
            compare_field("avg_gyr_z", 32'(want.avg_gyr_z), 32'(got.avg_gyr_z));
            compare_field("samples_seen", 32'(want.samples_seen), 32'(got.samples_seen));
            compare_field("init_done", 32'(want.init_done), 32'(got.init_done));
        endtask
    endclass

    localparam logic [SAMPLE_WIDTH-1:0] CORNER [12] = '{
        24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h000000, 24'hFFFFFF, 24'h000001,
        24'h555555, 24'hAAAAAA, 24'h010000, 24'hFF0000, 24'h7FFFFE, 24'h800001
    };

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_in_valid  = 1'b0;
    t_imu_in            i_in_data   = '0;
    logic               i_out_ready = 1'b0;
    logic               i_cfg_we    = 1'b0;
    logic [LIMIT_W-1:0] i_cfg_data  = '0;
    logic               o_in_ready;
    logic               o_out_valid;
    t_imu_out           o_out_data;

    mean_scoreboard          sb;
    int                      in_idle_pct   = 0;
    int                      out_stall_pct = 0;
    int                      hold_request  = 0;
    int                      hold_left     = 0;
    logic [SAMPLE_WIDTH-1:0] axis_bias [AXES];

    imu_bias_running_mean uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // output side: random stalls, or a long hold-off when one is requested
    always @(posedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= out_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && o_in_ready) sb.note_request(i_in_data);
            if (o_out_valid && i_out_ready) sb.check_result(o_out_data);
        end
    end

    function automatic t_imu_in pack_request(input logic [SAMPLE_WIDTH-1:0] s [AXES],
                                             input bit ge);
        t_imu_in req;
        req.acc_x     = s[0];
        req.acc_y     = s[1];
        req.acc_z     = s[2];
        req.gyr_x     = s[3];
        req.gyr_y     = s[4];
        req.gyr_z     = s[5];
        req.group_end = ge;
        return req;
    endfunction

    // mostly a still sensor around a bias, some full-range and corner samples
    function automatic t_imu_in random_request();
        logic [SAMPLE_WIDTH-1:0] s [AXES];
        int                      amp;
        for (int a = 0; a < AXES; a++) begin
            case ($urandom_range(9))
                0, 1: s[a] = SAMPLE_WIDTH'($urandom);
                2: s[a] = CORNER[$urandom_range(11)];
                default: begin
                    amp  = 1 << $urandom_range(2, 14);
                    s[a] = axis_bias[a] + SAMPLE_WIDTH'($urandom_range(2 * amp) - amp);
                end
            endcase
        end
        return pack_request(s, $urandom_range(5) == 0);
    endfunction

    task automatic offer(t_imu_in req);
        int gap;
        gap = 0;
        if (in_idle_pct != 0) begin
            if ($urandom_range(15) == 0) gap = $urandom_range(1, 200);
            while ($urandom_range(99) < in_idle_pct) gap++;
        end
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.expected_means.size() != 0);
    endtask

    task automatic write_limit(int unsigned value);
        wait_drained();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= LIMIT_W'(value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.set_limit(value);
    endtask

    initial begin
        logic [SAMPLE_WIDTH-1:0] s [AXES];
        t_imu_in                 req;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // corners first; the first request seeds the means
        write_limit(16'hFFFF);
        for (int k = 0; k < 18; k++) begin
            for (int a = 0; a < AXES; a++) s[a] = CORNER[(k + a) % 12];
            offer(pack_request(s, k % 4 == 3));
        end

        // limit kept above any count reached here so the means keep moving
        for (int chunk = 0; chunk < 8; chunk++) begin
            case (chunk % 4)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 51; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 51; end
                default: begin in_idle_pct = 19; out_stall_pct = 19; end
            endcase
            if (chunk != 0) write_limit($urandom_range(65534, 2000));
            foreach (axis_bias[a]) axis_bias[a] = SAMPLE_WIDTH'($urandom);
            repeat (130) offer(random_request());
        end

        in_idle_pct   = 0;
        out_stall_pct = 0;
        // count lands exactly on the limit at a group end: must not finish
        write_limit(sb.divisor + 1);
        req = random_request();
        req.group_end = 1'b1;
        offer(req);
        // count already past the limit inside a group: means still update
        write_limit(1);
        repeat (4) begin
            req = random_request();
            req.group_end = 1'b0;
            offer(req);
        end
        write_limit(0);
        repeat (3) begin
            req = random_request();
            req.group_end = 1'b0;
            offer(req);
        end
        req = random_request();
        req.group_end = 1'b1;
        offer(req);

        // frozen from here; long output hold-off backs up the input side
        write_limit(16'hFFFF);
        hold_request = 300;
        repeat (40) offer(random_request());
        in_idle_pct   = 51;
        out_stall_pct = 51;
        repeat (20) offer(random_request());

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (sb.expected_means.size() != 0)
            sb.report($sformatf("%0d results never arrived", sb.expected_means.size()));
        if (sb.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("tb: errors");
        $finish;
    end

endmodule
